// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the checkers of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define LCA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("assertion failed in %m");

// Checked on every rising edge, reset included.
`define LCA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed in %m");

`endif

// ===== sv/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// LCA package
// Widths, codes and table entry type of the lowest common ancestor block.
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int unsigned NODES      = 1024;
  localparam int unsigned NODE_W     = $clog2(NODES);
  localparam int unsigned DEPTH_W    = NODE_W + 1;
  localparam int unsigned BSIZE_W    = 11;
  localparam int unsigned STEP_LIMIT = 2 * NODES + 2;
  localparam int unsigned STEP_W     = $clog2(STEP_LIMIT + 1);
  localparam int unsigned DIV_CNT_W  = $clog2(NODE_W);

  localparam int unsigned S_TDATA_W  = ((2 * NODE_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W  = ((NODE_W + 7) / 8) * 8;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic FUNC_ATTACH = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic REG_IDX_BLOCK_SIZE = 1'b0;
  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RESET = BSIZE_W'(1);

  typedef struct packed {
    logic [NODE_W-1:0]        parent;
    logic [NODE_W-1:0]        jump;
    logic signed [DEPTH_W-1:0] depth;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  localparam entry_t SENTINEL = '{parent: '0, jump: '0, depth: '1};

endpackage

// ===== sv/lca_ram.sv =====
// ----------------------------------------------------------------------------
// LCA RAM
// Generic synchronous RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/lca_sqrt_decomposition.sv =====
// ----------------------------------------------------------------------------
// Lowest common ancestor by square-root decomposition
// Tree tables in one RAM, with attach and query transactions.
// ----------------------------------------------------------------------------
// Input transactions arrive on the s_axis channel: tuser selects attach (0) or
// query (1), tdata carries the node and the other node. An attach stores the
// node under its parent and gives no result. A query gives one result on the
// m_axis channel, the lowest common ancestor of the two nodes.
// One transaction is worked on at a time; s_axis_tready is high when idle.
// An attach works through one RAM read of the parent, a remainder unit for the
// depth test against block_size, and one RAM write. Attaching node 0 is
// dropped at once. A query climbs by jump and parent steps, and each step is
// one read of the table RAM. The result sits in an output register, so a
// stalled receiver does not stop the next transaction from being taken; a
// finished query waits only if that register is still full. block_size is
// written over the APB port; the user must write it only while idle, as the
// block itself does not enforce this.
// Reset clears control state and sets block_size to 1; the tables need no
// clearing pass, since the sentinel node 0 is never written and is supplied
// by logic.
// ----------------------------------------------------------------------------
module lca_sqrt_decomposition
  import lca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // node, other_node, zero fill
  input  logic                 s_axis_tuser,   // func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // ancestor, zero fill
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ATT_LOAD = 7'b0000010,
    S_ATT_DIV  = 7'b0000100,
    S_ATT_WR   = 7'b0001000,
    S_Q_LOAD   = 7'b0010000,
    S_Q_STEP   = 7'b0100000,
    S_Q_FETCH  = 7'b1000000
  } state_e;

  localparam logic signed [DEPTH_W:0] DEPTH_MAX_X = (DEPTH_W + 1)'(NODES - 1);
  localparam logic [DIV_CNT_W-1:0]    DIV_LAST    = DIV_CNT_W'(NODE_W - 1);

  state_e                state_q, state_d;
  logic [NODE_W-1:0]     u_q, u_d, v_q, v_d;
  entry_t                eu_q, eu_d, ev_q, ev_d;
  logic                  jump_phase_q, jump_phase_d;
  logic [STEP_W-1:0]     steps_q, steps_d;
  logic [DEPTH_W-1:0]    dep_q, dep_d;
  logic [NODE_W-1:0]     div_q, div_d;
  logic [BSIZE_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [NODE_W-1:0]     out_data_q, out_data_d;
  logic [BSIZE_W-1:0]    block_size_q, block_size_d;

  entry_t                rdata_a, rdata_b, ent_a, ent_b, wdata;
  logic                  we;
  logic                  s_accept, out_free, swap, at_limit;
  logic [NODE_W-1:0]     in_node, in_other, lo_node;
  entry_t                lo_ent, hi_ent;
  logic [BSIZE_W-1:0]    bsize_eff;
  logic signed [DEPTH_W:0] dep_sum;
  logic [DEPTH_W-1:0]    dep_new;
  logic [BSIZE_W:0]      trial, trial_sub;
  logic                  cfg_write;

  lca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (u_q),
    .wdata_i   (wdata),
    .raddr_a_i (u_d),
    .rdata_a_o (rdata_a),
    .raddr_b_i (v_d),
    .rdata_b_o (rdata_b)
  );

  assign in_node  = s_axis_tdata[NODE_W-1:0];
  assign in_other = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept = s_axis_tvalid & s_axis_tready;
  assign out_free = ~out_valid_q | m_axis_tready;

  assign ent_a = (u_q == '0) ? SENTINEL : rdata_a;
  assign ent_b = (v_q == '0) ? SENTINEL : rdata_b;

  assign bsize_eff = (block_size_q == '0) ? BSIZE_W'(1) : block_size_q;

  assign dep_sum = $signed({ent_b.depth[DEPTH_W-1], ent_b.depth}) + (DEPTH_W + 1)'(1);
  assign dep_new = (dep_sum > DEPTH_MAX_X) ? DEPTH_W'(NODES - 1) : dep_sum[DEPTH_W-1:0];

  assign trial     = {rem_q, div_q[NODE_W-1]};
  assign trial_sub = trial - {1'b0, bsize_eff};

  assign swap    = $signed(eu_q.depth) > $signed(ev_q.depth);
  assign lo_node = swap ? v_q : u_q;
  assign lo_ent  = swap ? ev_q : eu_q;
  assign hi_ent  = swap ? eu_q : ev_q;
  assign at_limit = (steps_q >= STEP_W'(STEP_LIMIT));

  assign wdata = '{parent: v_q,
                   jump:   (rem_q == '0) ? v_q : ev_q.jump,
                   depth:  dep_q};

  always_comb begin
    state_d      = state_q;
    u_d          = u_q;
    v_d          = v_q;
    eu_d         = eu_q;
    ev_d         = ev_q;
    jump_phase_d = jump_phase_q;
    steps_d      = steps_q;
    dep_d        = dep_q;
    div_d        = div_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_data_d   = out_data_q;
    we           = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          u_d = in_node;
          v_d = in_other;
          if (s_axis_tuser == FUNC_QUERY) begin
            state_d = S_Q_LOAD;
          end else if (in_node != '0) begin
            state_d = S_ATT_LOAD;
          end
        end
      end
      S_ATT_LOAD: begin
        ev_d    = ent_b;
        dep_d   = dep_new;
        div_d   = dep_new[NODE_W-1:0];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_ATT_DIV;
      end
      S_ATT_DIV: begin
        div_d = div_q << 1;
        if (trial >= {1'b0, bsize_eff}) begin
          rem_d = trial_sub[BSIZE_W-1:0];
        end else begin
          rem_d = trial[BSIZE_W-1:0];
        end
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = S_ATT_WR;
        end
      end
      S_ATT_WR: begin
        we      = 1'b1;
        state_d = S_IDLE;
      end
      S_Q_LOAD: begin
        eu_d         = ent_a;
        ev_d         = ent_b;
        steps_d      = '0;
        jump_phase_d = 1'b1;
        state_d      = S_Q_STEP;
      end
      S_Q_STEP: begin
        if (jump_phase_q && (eu_q.jump == ev_q.jump)) begin
          jump_phase_d = 1'b0;
        end else if (jump_phase_q || (u_q != v_q)) begin
          if (at_limit) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_data_d  = '0;
              state_d     = S_IDLE;
            end
          end else begin
            steps_d = steps_q + STEP_W'(1);
            u_d     = lo_node;
            eu_d    = lo_ent;
            v_d     = jump_phase_q ? hi_ent.jump : hi_ent.parent;
            state_d = S_Q_FETCH;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = u_q;
          state_d     = S_IDLE;
        end
      end
      S_Q_FETCH: begin
        ev_d    = ent_b;
        state_d = S_Q_STEP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cfg_write    = psel & penable & pwrite & pready
                        & (paddr[PADDR_W-1] == REG_IDX_BLOCK_SIZE);
  assign block_size_d = cfg_write ? pwdata[BSIZE_W-1:0] : block_size_q;
  assign pready       = 1'b1;
  assign prdata       = (paddr[PADDR_W-1] == REG_IDX_BLOCK_SIZE) ?
                        PDATA_W'(block_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      jump_phase_q <= 1'b0;
      steps_q      <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      block_size_q <= BLOCK_SIZE_RESET;
    end else begin
      state_q      <= state_d;
      jump_phase_q <= jump_phase_d;
      steps_q      <= steps_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      block_size_q <= block_size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q        <= u_d;
    v_q        <= v_d;
    eu_q       <= eu_d;
    ev_q       <= ev_d;
    dep_q      <= dep_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_data_q);

endmodule

// ===== sv/lca_checker.sv =====
// ----------------------------------------------------------------------------
// LCA checker
// Port-level assertions for the lowest common ancestor block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lca_checker
  import lca_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,   // node, other_node, zero fill
  input logic                 s_axis_tuser,   // func
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata    // ancestor, zero fill
);

  logic s_accept;
  logic m_wait;
  logic null_attach;

  assign s_accept    = s_axis_tvalid && s_axis_tready;
  assign m_wait      = m_axis_tvalid && !m_axis_tready;
  assign null_attach = (s_axis_tuser == FUNC_ATTACH) && (s_axis_tdata[NODE_W-1:0] == '0);

  // A result held back by the receiver stays put.
  `LCA_ASSERT(a_out_hold, clk_i, rst_ni, m_wait |=> m_axis_tvalid && $stable(m_axis_tdata))

  // No result is offered after reset is sampled low.
  `LCA_ASSERT_ALWAYS(a_out_reset, clk_i, !rst_ni |=> !m_axis_tvalid)

  // Any transaction other than an attach of node 0 makes the block busy.
  `LCA_ASSERT(a_busy_after_accept, clk_i, rst_ni, s_accept && !null_attach |=> !s_axis_tready)

  // A new result only appears after the block was busy with a query.
  `LCA_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

endmodule

bind lca_sqrt_decomposition lca_checker u_lca_checker (.*);
